[design/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Token kinds, character codes and the keyword table of the token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

	localparam int KIND_BITS = 7;
	localparam int KW_COUNT  = 29;
	localparam int KW_SLOT   = 9;

	localparam logic [6:0] K_EOF     = 7'd0;
	localparam logic [6:0] K_IDENT   = 7'd1;
	localparam logic [6:0] K_NUMBER  = 7'd2;
	localparam logic [6:0] K_STRING  = 7'd3;
	localparam logic [6:0] K_UNKNOWN = 7'd4;
	localparam logic [6:0] K_KW0     = 7'd5;
	localparam logic [6:0] K_PLUS    = 7'd34;
	localparam logic [6:0] K_ARROW   = 7'd35;
	localparam logic [6:0] K_MINUS   = 7'd36;
	localparam logic [6:0] K_STAR    = 7'd37;
	localparam logic [6:0] K_SLASH   = 7'd38;
	localparam logic [6:0] K_PERCENT = 7'd39;
	localparam logic [6:0] K_EQEQ    = 7'd40;
	localparam logic [6:0] K_ASSIGN  = 7'd41;
	localparam logic [6:0] K_NOTEQ   = 7'd42;
	localparam logic [6:0] K_BANG    = 7'd43;
	localparam logic [6:0] K_LE      = 7'd44;
	localparam logic [6:0] K_SHL     = 7'd45;
	localparam logic [6:0] K_LT      = 7'd46;
	localparam logic [6:0] K_GE      = 7'd47;
	localparam logic [6:0] K_SHR     = 7'd48;
	localparam logic [6:0] K_GT      = 7'd49;
	localparam logic [6:0] K_ANDAND  = 7'd50;
	localparam logic [6:0] K_AMP     = 7'd51;
	localparam logic [6:0] K_OROR    = 7'd52;
	localparam logic [6:0] K_PIPE    = 7'd53;
	localparam logic [6:0] K_CARET   = 7'd54;
	localparam logic [6:0] K_TILDE   = 7'd55;
	localparam logic [6:0] K_LPAREN  = 7'd56;
	localparam logic [6:0] K_RPAREN  = 7'd57;
	localparam logic [6:0] K_LBRACE  = 7'd58;
	localparam logic [6:0] K_RBRACE  = 7'd59;
	localparam logic [6:0] K_LBRACK  = 7'd60;
	localparam logic [6:0] K_RBRACK  = 7'd61;
	localparam logic [6:0] K_SEMI    = 7'd62;
	localparam logic [6:0] K_COMMA   = 7'd63;
	localparam logic [6:0] K_ELLIPS  = 7'd64;
	localparam logic [6:0] K_DOTDOT  = 7'd65;
	localparam logic [6:0] K_DOT     = 7'd66;
	localparam logic [6:0] K_COLON   = 7'd67;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	localparam logic [8*KW_SLOT-1:0] KW_TEXT [KW_COUNT] = '{
		"struct", "let", "mut", "const", "fn", "return", "extern", "true", "false",
		"if", "else", "for", "while", "break", "continue", "defer", "errdefer",
		"try", "catch", "error", "null", "interface", "impl", "atomic", "max",
		"min", "as", "type", "mc"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd3, 4'd3, 4'd5, 4'd2, 4'd6, 4'd6, 4'd4, 4'd5, 4'd2, 4'd4, 4'd3,
		4'd5, 4'd5, 4'd8, 4'd5, 4'd8, 4'd3, 4'd5, 4'd5, 4'd4, 4'd9, 4'd4, 4'd6,
		4'd3, 4'd3, 4'd2, 4'd4, 4'd2
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [6:0] word_kind(input logic [KW_SLOT-1:0][7:0] w,
		input logic [15:0] len, input logic ovf);
		logic [6:0] k;
		logic       same;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			same = (len == {12'd0, KW_LEN[i]});
			for (int j = 0; j < KW_SLOT; j++) begin
				if (j < int'(KW_LEN[i]) &&
					w[j] != KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8])
					same = 1'b0;
			end
			if (same)
				k = K_KW0 + 7'(i);
		end
		if (ovf)
			k = K_IDENT;
		return k;
	endfunction

	function automatic logic [6:0] single_kind(input logic [7:0] p);
		logic [6:0] k;
		unique case (p)
			"-":     k = K_MINUS;
			"=":     k = K_ASSIGN;
			"!":     k = K_BANG;
			"<":     k = K_LT;
			">":     k = K_GT;
			"&":     k = K_AMP;
			"|":     k = K_PIPE;
			"/":     k = K_SLASH;
			default: k = K_DOT;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		logic [6:0] k;
		k = K_EOF;
		if (p == "-" && c == ">") k = K_ARROW;
		if (p == "=" && c == "=") k = K_EQEQ;
		if (p == "!" && c == "=") k = K_NOTEQ;
		if (p == "<" && c == "=") k = K_LE;
		if (p == "<" && c == "<") k = K_SHL;
		if (p == ">" && c == "=") k = K_GE;
		if (p == ">" && c == ">") k = K_SHR;
		if (p == "&" && c == "&") k = K_ANDAND;
		if (p == "|" && c == "|") k = K_OROR;
		return k;
	endfunction

	function automatic logic [6:0] immediate_kind(input logic [7:0] c);
		logic [6:0] k;
		unique case (c)
			"+":     k = K_PLUS;
			"*":     k = K_STAR;
			"%":     k = K_PERCENT;
			"^":     k = K_CARET;
			"~":     k = K_TILDE;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"[":     k = K_LBRACK;
			"]":     k = K_RBRACK;
			";":     k = K_SEMI;
			",":     k = K_COMMA;
			":":     k = K_COLON;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

	function automatic logic is_pend_char(input logic [7:0] c);
		return c == "-" || c == "=" || c == "!" || c == "<" || c == ">" ||
			c == "&" || c == "|" || c == "." || c == "/";
	endfunction

endpackage

`default_nettype wire

[design/sts_byte_if.sv]
// ----------------------------------------------------------------------------
// sts_byte_if
// Source text channel: one byte and its last-byte mark per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

[design/sts_token_if.sv]
// ----------------------------------------------------------------------------
// sts_token_if
// Token channel: kind, start position, length and status per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_token_if #(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [6:0]             token_kind;
	logic [LINE_BITS-1:0]   start_line;
	logic [COLUMN_BITS-1:0] start_column;
	logic [15:0]            token_length;
	logic [7:0]             odd_byte;
	logic                   stream_done;

	modport source (output valid, output token_kind, output start_line,
		output start_column, output token_length, output odd_byte,
		output stream_done, input ready);
	modport sink (input valid, input token_kind, input start_line,
		input start_column, input token_length, input odd_byte,
		input stream_done, output ready);
endinterface

`default_nettype wire

[design/source_token_scanner_unit.sv]
// ----------------------------------------------------------------------------
// source_token_scanner_unit
// Byte-serial lexer: skips blanks and comments, reports one token per lexeme.
// ----------------------------------------------------------------------------
// Channels: text (sink) takes one source byte per transfer with its last-byte
// mark; tokens (source) gives one token per transfer: kind, start line and
// column, length, offending byte for unknown bytes, and a done flag on the
// end token.
// Path: a byte waits in the input register until the queue has room; its
// tokens (zero to three) are then written to a four-entry output queue,
// and are visible on tokens once that write is registered.
// Throughput: one byte per cycle while the queue keeps three free entries;
// the single queue read port drains one token per cycle while tokens
// is ready.
// Reset: all scanner state returns to between-tokens at line 1, column 1;
// the queue empties. The same state is restored after every last byte.
// Stall: when tokens is not ready the queue fills, the input register holds
// its byte, and text ready drops until room returns.
// ----------------------------------------------------------------------------
`default_nettype none

module source_token_scanner_unit #(
	parameter int KEYWORD_MAX_LEN = 9,
	parameter int LINE_BITS       = 20,
	parameter int COLUMN_BITS     = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	sts_byte_if.sink            text,
	sts_token_if.source         tokens
);
	import sts_pkg::*;

	localparam int IDXW = $clog2(KEYWORD_MAX_LEN);
	localparam logic [LINE_BITS-1:0]   LMAX = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] CMAX = {COLUMN_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LONE = LINE_BITS'(1);
	localparam logic [COLUMN_BITS-1:0] CONE = COLUMN_BITS'(1);

	typedef enum logic [3:0] {
		M_NORMAL, M_PEND, M_IDENT, M_NUMBER, M_STRING, M_STR_ESC,
		M_LINE_CMT, M_BLOCK, M_BLOCK_STAR
	} mode_t;

	typedef struct packed {
		logic [6:0]             kind;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [15:0]            len;
		logic [7:0]             odd;
		logic                   done;
	} tok_t;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   fin_s1;

	mode_t                  mode_q;
	logic [7:0]             pend_q;
	logic [1:0]             dot_q;
	logic [7:0]             wbuf_q [KEYWORD_MAX_LEN];
	logic                   wovf_q;
	logic [15:0]            runl_q;
	logic [LINE_BITS-1:0]   tl_q, cl_q;
	logic [COLUMN_BITS-1:0] tc_q, cc_q;
	logic                   ended_q;

	tok_t                   fifo_q [4];
	logic [1:0]             wr_q, rd_q;
	logic [2:0]             cnt_q;

	logic                   process;
	mode_t                  mode_n;
	logic [7:0]             pend_n;
	logic [1:0]             dot_n;
	logic                   wovf_n;
	logic [15:0]            runl_n;
	logic [LINE_BITS-1:0]   tl_n, cl_n;
	logic [COLUMN_BITS-1:0] tc_n, cc_n;
	logic                   ended_n;
	logic                   we;
	logic [IDXW-1:0]        waddr;
	tok_t                   er [3];
	logic [1:0]             en;
	logic [KW_SLOT-1:0][7:0] bufp, bufn;
	logic                   pop;

	assign process    = valid_s1 && (cnt_q <= 3'd1);
	assign text.ready = !valid_s1 || process;
	assign pop        = tokens.valid && tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			fin_s1  <= text.final_byte;
		end
	end

	function automatic void flush_tok(input mode_t m, input logic [7:0] p,
		input logic [1:0] d, input logic [15:0] rl, input logic [6:0] wk,
		output logic has, output logic [6:0] k, output logic [15:0] l);
		has = 1'b1;
		k   = K_EOF;
		l   = rl;
		unique case (m)
			M_IDENT:  k = wk;
			M_NUMBER: k = K_NUMBER;
			M_STRING, M_STR_ESC: k = K_STRING;
			M_PEND: begin
				if (p == ".") begin
					k = (d == 2'd2) ? K_DOTDOT : K_DOT;
					l = (d == 2'd2) ? 16'd2 : 16'd1;
				end else begin
					k = single_kind(p);
					l = 16'd1;
				end
			end
			default: has = 1'b0;
		endcase
	endfunction

	always_comb begin
		logic [7:0]  c;
		logic        go_start;
		logic        fh;
		logic [6:0]  fk, pk;
		logic [15:0] fl;

		c       = byte_s1;
		mode_n  = mode_q;
		pend_n  = pend_q;
		dot_n   = dot_q;
		wovf_n  = wovf_q;
		runl_n  = runl_q;
		tl_n    = tl_q;
		tc_n    = tc_q;
		cl_n    = cl_q;
		cc_n    = cc_q;
		ended_n = ended_q;
		we      = 1'b0;
		waddr   = '0;
		en      = 2'd0;
		go_start = 1'b0;
		fh = 1'b0;
		fk = K_EOF;
		fl = 16'd0;
		pk = pair_kind(pend_q, c);
		for (int i = 0; i < 3; i++)
			er[i] = '0;
		for (int j = 0; j < KW_SLOT; j++)
			bufp[j] = wbuf_q[j];

		flush_tok(mode_q, pend_q, dot_q, runl_q, word_kind(bufp, runl_q, wovf_q),
			fh, fk, fl);

		if (!ended_q) begin
			if (c == CH_NUL) begin
				if (fh) begin
					er[en] = '{fk, tl_n, tc_n, fl, 8'd0, 1'b0};
					en = en + 2'd1;
				end
				mode_n  = M_NORMAL;
				ended_n = 1'b1;
			end else begin
				unique case (mode_q)
					M_IDENT: begin
						if (is_alpha(c) || is_digit(c) || c == "_") begin
							if (runl_q < 16'(KEYWORD_MAX_LEN)) begin
								we    = 1'b1;
								waddr = runl_q[IDXW-1:0];
							end else begin
								wovf_n = 1'b1;
							end
							if (runl_n != 16'hFFFF) runl_n = runl_n + 16'd1;
						end else begin
							go_start = 1'b1;
						end
					end
					M_NUMBER: begin
						if (is_digit(c) || c == ".") begin
							if (runl_n != 16'hFFFF) runl_n = runl_n + 16'd1;
						end else begin
							go_start = 1'b1;
						end
					end
					M_STRING: begin
						if (runl_n != 16'hFFFF) runl_n = runl_n + 16'd1;
						if (c == CH_QUOTE) begin
							er[en] = '{K_STRING, tl_n, tc_n, runl_n, 8'd0, 1'b0};
							en = en + 2'd1;
							mode_n = M_NORMAL;
						end else if (c == CH_BSL) begin
							mode_n = M_STR_ESC;
						end
					end
					M_STR_ESC: begin
						if (runl_n != 16'hFFFF) runl_n = runl_n + 16'd1;
						mode_n = M_STRING;
					end
					M_LINE_CMT: begin
						if (c == CH_LF) begin
							mode_n   = M_NORMAL;
							go_start = 1'b1;
						end
					end
					M_BLOCK: begin
						if (c == "*") mode_n = M_BLOCK_STAR;
					end
					M_BLOCK_STAR: begin
						if (c == "/") mode_n = M_NORMAL;
						else if (c != "*") mode_n = M_BLOCK;
					end
					M_PEND: begin
						if (pend_q == "/") begin
							if (c == "/") mode_n = M_LINE_CMT;
							else if (c == "*") mode_n = M_BLOCK;
							else go_start = 1'b1;
						end else if (pend_q == ".") begin
							if (c == ".") begin
								if (dot_q == 2'd1) begin
									dot_n = 2'd2;
								end else begin
									er[en] = '{K_ELLIPS, tl_n, tc_n, 16'd3, 8'd0, 1'b0};
									en = en + 2'd1;
									mode_n = M_NORMAL;
								end
							end else begin
								go_start = 1'b1;
							end
						end else if (pk != K_EOF) begin
							er[en] = '{pk, tl_n, tc_n, 16'd2, 8'd0, 1'b0};
							en = en + 2'd1;
							mode_n = M_NORMAL;
						end else begin
							go_start = 1'b1;
						end
					end
					default: go_start = 1'b1;
				endcase

				if (go_start && mode_q != M_NORMAL && mode_q != M_LINE_CMT) begin
					if (fh) begin
						er[en] = '{fk, tl_n, tc_n, fl, 8'd0, 1'b0};
						en = en + 2'd1;
					end
					mode_n = M_NORMAL;
				end

				if (go_start && !(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
					tl_n   = cl_q;
					tc_n   = cc_q;
					runl_n = 16'd1;
					if (immediate_kind(c) != K_EOF) begin
						er[en] = '{immediate_kind(c), tl_n, tc_n, 16'd1, 8'd0, 1'b0};
						en = en + 2'd1;
					end else if (is_pend_char(c)) begin
						mode_n = M_PEND;
						pend_n = c;
						dot_n  = 2'd1;
					end else if (c == CH_QUOTE) begin
						mode_n = M_STRING;
					end else if (is_alpha(c) || c == "_") begin
						mode_n = M_IDENT;
						wovf_n = 1'b0;
						we     = 1'b1;
						waddr  = '0;
					end else if (is_digit(c)) begin
						mode_n = M_NUMBER;
					end else begin
						er[en] = '{K_UNKNOWN, tl_n, tc_n, 16'd1, c, 1'b0};
						en = en + 2'd1;
					end
				end

				if (!(mode_q == M_LINE_CMT && c == CH_LF && !go_start) &&
					!((mode_q == M_IDENT || mode_q == M_NUMBER) && go_start &&
					(c == CH_SPACE || c == CH_TAB || c == CH_CR) && 1'b0)) begin
					if (c == CH_LF) begin
						if (cl_q != LMAX) cl_n = cl_q + LONE;
						cc_n = CONE;
					end else if (cc_q != CMAX) begin
						cc_n = cc_q + CONE;
					end
				end
			end
		end

		if (fin_s1) begin
			bufn = bufp;
			for (int j = 0; j < KW_SLOT; j++)
				if (we && 32'(waddr) == j) bufn[j] = c;
			flush_tok(mode_n, pend_n, dot_n, runl_n, word_kind(bufn, runl_n, wovf_n),
				fh, fk, fl);
			if (fh) begin
				er[en] = '{fk, tl_n, tc_n, fl, 8'd0, 1'b0};
				en = en + 2'd1;
			end
			er[en] = '{K_EOF, cl_n, cc_n, 16'd0, 8'd0, 1'b1};
			en = en + 2'd1;
			mode_n  = M_NORMAL;
			pend_n  = 8'd0;
			dot_n   = 2'd0;
			wovf_n  = 1'b0;
			runl_n  = 16'd0;
			tl_n    = LONE;
			tc_n    = CONE;
			cl_n    = LONE;
			cc_n    = CONE;
			ended_n = 1'b0;
		end else begin
			bufn = bufp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			pend_q  <= 8'd0;
			dot_q   <= 2'd0;
			wovf_q  <= 1'b0;
			runl_q  <= 16'd0;
			tl_q    <= LONE;
			tc_q    <= CONE;
			cl_q    <= LONE;
			cc_q    <= CONE;
			ended_q <= 1'b0;
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			cnt_q   <= 3'd0;
		end else begin
			if (process) begin
				mode_q  <= mode_n;
				pend_q  <= pend_n;
				dot_q   <= dot_n;
				wovf_q  <= wovf_n;
				runl_q  <= runl_n;
				tl_q    <= tl_n;
				tc_q    <= tc_n;
				cl_q    <= cl_n;
				cc_q    <= cc_n;
				ended_q <= ended_n;
				wr_q    <= wr_q + en;
			end
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + (process ? {1'b0, en} : 3'd0) - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (process && we && !fin_s1)
			wbuf_q[waddr] <= byte_s1;
		if (process) begin
			for (int i = 0; i < 3; i++)
				if (2'(i) < en)
					fifo_q[wr_q + 2'(i)] <= er[i];
		end
	end

	assign tokens.valid        = (cnt_q != 3'd0);
	assign tokens.token_kind   = fifo_q[rd_q].kind;
	assign tokens.start_line   = fifo_q[rd_q].line;
	assign tokens.start_column = fifo_q[rd_q].col;
	assign tokens.token_length = fifo_q[rd_q].len;
	assign tokens.odd_byte     = fifo_q[rd_q].odd;
	assign tokens.stream_done  = fifo_q[rd_q].done;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("token queue overfilled");

	a_done_eof: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.stream_done |-> tokens.token_kind == K_EOF &&
		tokens.token_length == 16'd0)
		else $error("done flag on a non-end token");

	a_fin_resets: assert property (@(posedge clk) disable iff (!arst_n)
		process && fin_s1 |=> mode_q == M_NORMAL && cl_q == LONE && cc_q == CONE)
		else $error("state not restored after last byte");

	a_stall_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cnt_q > 3'd1 |-> !text.ready)
		else $error("byte taken without queue room");

endmodule

`default_nettype wire

[sim/tb_source_token_scanner_unit.sv]
// ----------------------------------------------------------------------------
// tb_source_token_scanner_unit
// Self-checking bench for the byte-serial token scanner.
// ----------------------------------------------------------------------------
// Sends source bytes through the text channel. A behavioral lexer follows each
// accepted byte and queues the tokens it implies. A checker process compares
// every token transfer with the oldest queued token, field by field. The
// sections are: directed lexemes, random token streams with noise, a long
// receiver hold-off and idling in both directions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_source_token_scanner_unit;
	import sts_pkg::*;

	localparam int LB = 20;
	localparam int CB = 16;
	localparam int KW_MAX = 9;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum int {
		SC_NORMAL, SC_PEND, SC_WORD, SC_NUMBER, SC_STRING, SC_STR_ESC,
		SC_LINE_CMT, SC_BLOCK, SC_BLOCK_STAR
	} scan_state_t;

	typedef struct packed {
		logic [6:0]    kind;
		logic [LB-1:0] line;
		logic [CB-1:0] column;
		logic [15:0]   length;
		logic [7:0]    odd;
		logic          done;
	} token_t;

	logic clk;
	logic arst_n;

	sts_byte_if text();
	sts_token_if #(.LINE_BITS(LB), .COLUMN_BITS(CB)) tokens();

	source_token_scanner_unit #(
		.KEYWORD_MAX_LEN(KW_MAX),
		.LINE_BITS(LB),
		.COLUMN_BITS(CB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.tokens(tokens)
	);

	token_t token_queue[$];
	int     error_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     hold_cycles;
	int     quiet_cycles;

	// lexer state
	scan_state_t   lx_state;
	logic [7:0]    lx_pend;
	int            lx_dots;
	logic [7:0]    lx_word[KW_MAX];
	logic          lx_ovf;
	int            lx_run;
	logic [LB-1:0] lx_tok_line;
	logic [CB-1:0] lx_tok_col;
	logic [LB-1:0] lx_line;
	logic [CB-1:0] lx_col;
	logic          lx_ended;

	string kw_names[KW_COUNT] = '{
		"struct", "let", "mut", "const", "fn", "return", "extern", "true", "false",
		"if", "else", "for", "while", "break", "continue", "defer", "errdefer",
		"try", "catch", "error", "null", "interface", "impl", "atomic", "max",
		"min", "as", "type", "mc"
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic lexer_reset();
		lx_state = SC_NORMAL;
		lx_pend = 8'd0;
		lx_dots = 0;
		lx_ovf = 1'b0;
		lx_run = 0;
		lx_tok_line = LB'(1);
		lx_tok_col = CB'(1);
		lx_line = LB'(1);
		lx_col = CB'(1);
		lx_ended = 1'b0;
	endtask

	task automatic push_token(logic [6:0] kind, int len, logic [7:0] odd, logic done);
		token_t t;
		t.kind = kind;
		t.line = lx_tok_line;
		t.column = lx_tok_col;
		t.length = (len > 65535) ? 16'hFFFF : 16'(len);
		t.odd = odd;
		t.done = done;
		token_queue.push_back(t);
	endtask

	task automatic advance_pos(logic [7:0] c);
		if (c == CH_LF) begin
			if (lx_line != {LB{1'b1}})
				lx_line++;
			lx_col = CB'(1);
		end else if (lx_col != {CB{1'b1}}) begin
			lx_col++;
		end
	endtask

	function automatic bit alpha_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [6:0] classify_word();
		string s;
		bit    hit;
		if (lx_ovf)
			return K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			s = kw_names[i];
			if (s.len() == lx_run && s.len() <= KW_MAX) begin
				hit = 1'b1;
				for (int j = 0; j < s.len(); j++)
					if (lx_word[j] != s[j])
						hit = 1'b0;
				if (hit)
					return K_KW0 + 7'(i);
			end
		end
		return K_IDENT;
	endfunction

	function automatic logic [6:0] lone_op(logic [7:0] p);
		case (p)
			"-": return K_MINUS;
			"=": return K_ASSIGN;
			"!": return K_BANG;
			"<": return K_LT;
			">": return K_GT;
			"&": return K_AMP;
			"|": return K_PIPE;
			"/": return K_SLASH;
			default: return K_DOT;
		endcase
	endfunction

	function automatic logic [6:0] double_op(logic [7:0] p, logic [7:0] c);
		if (p == "-" && c == ">") return K_ARROW;
		if (p == "=" && c == "=") return K_EQEQ;
		if (p == "!" && c == "=") return K_NOTEQ;
		if (p == "<" && c == "=") return K_LE;
		if (p == "<" && c == "<") return K_SHL;
		if (p == ">" && c == "=") return K_GE;
		if (p == ">" && c == ">") return K_SHR;
		if (p == "&" && c == "&") return K_ANDAND;
		if (p == "|" && c == "|") return K_OROR;
		return K_EOF;
	endfunction

	function automatic logic [6:0] single_op(logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"*": return K_STAR;
			"%": return K_PERCENT;
			"^": return K_CARET;
			"~": return K_TILDE;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"[": return K_LBRACK;
			"]": return K_RBRACK;
			";": return K_SEMI;
			",": return K_COMMA;
			":": return K_COLON;
			default: return K_EOF;
		endcase
	endfunction

	task automatic close_token();
		case (lx_state)
			SC_WORD: push_token(classify_word(), lx_run, 8'd0, 1'b0);
			SC_NUMBER: push_token(K_NUMBER, lx_run, 8'd0, 1'b0);
			SC_STRING, SC_STR_ESC: push_token(K_STRING, lx_run, 8'd0, 1'b0);
			SC_PEND: begin
				if (lx_pend == ".")
					push_token(lx_dots == 2 ? K_DOTDOT : K_DOT, lx_dots == 2 ? 2 : 1,
						8'd0, 1'b0);
				else
					push_token(lone_op(lx_pend), 1, 8'd0, 1'b0);
			end
			default: ;
		endcase
		lx_state = SC_NORMAL;
	endtask

	task automatic begin_token(logic [7:0] c);
		logic [6:0] k;
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
			advance_pos(c);
			return;
		end
		lx_tok_line = lx_line;
		lx_tok_col = lx_col;
		advance_pos(c);
		lx_run = 1;
		k = single_op(c);
		if (k != K_EOF) begin
			push_token(k, 1, 8'd0, 1'b0);
		end else if (c == "-" || c == "=" || c == "!" || c == "<" || c == ">" ||
				c == "&" || c == "|" || c == "." || c == "/") begin
			lx_state = SC_PEND;
			lx_pend = c;
			lx_dots = 1;
		end else if (c == CH_QUOTE) begin
			lx_state = SC_STRING;
		end else if (alpha_char(c) || c == "_") begin
			lx_state = SC_WORD;
			lx_ovf = 1'b0;
			lx_word[0] = c;
		end else if (digit_char(c)) begin
			lx_state = SC_NUMBER;
		end else begin
			push_token(K_UNKNOWN, 1, c, 1'b0);
		end
	endtask

	task automatic lex_byte(logic [7:0] c);
		logic [6:0] k;
		case (lx_state)
			SC_WORD: begin
				if (alpha_char(c) || digit_char(c) || c == "_") begin
					if (lx_run < KW_MAX)
						lx_word[lx_run] = c;
					else
						lx_ovf = 1'b1;
					if (lx_run < 65535)
						lx_run++;
					advance_pos(c);
					return;
				end
				close_token();
			end
			SC_NUMBER: begin
				if (digit_char(c) || c == ".") begin
					if (lx_run < 65535)
						lx_run++;
					advance_pos(c);
					return;
				end
				close_token();
			end
			SC_STRING: begin
				advance_pos(c);
				if (lx_run < 65535)
					lx_run++;
				if (c == CH_QUOTE) begin
					push_token(K_STRING, lx_run, 8'd0, 1'b0);
					lx_state = SC_NORMAL;
				end else if (c == CH_BSL) begin
					lx_state = SC_STR_ESC;
				end
				return;
			end
			SC_STR_ESC: begin
				advance_pos(c);
				if (lx_run < 65535)
					lx_run++;
				lx_state = SC_STRING;
				return;
			end
			SC_LINE_CMT: begin
				if (c == CH_LF) begin
					lx_state = SC_NORMAL;
				end else begin
					advance_pos(c);
					return;
				end
			end
			SC_BLOCK: begin
				advance_pos(c);
				if (c == "*")
					lx_state = SC_BLOCK_STAR;
				return;
			end
			SC_BLOCK_STAR: begin
				advance_pos(c);
				if (c == "/")
					lx_state = SC_NORMAL;
				else if (c != "*")
					lx_state = SC_BLOCK;
				return;
			end
			SC_PEND: begin
				if (lx_pend == "/") begin
					if (c == "/" || c == "*") begin
						advance_pos(c);
						lx_state = (c == "/") ? SC_LINE_CMT : SC_BLOCK;
						return;
					end
					close_token();
				end else if (lx_pend == ".") begin
					if (c == ".") begin
						advance_pos(c);
						if (lx_dots == 1) begin
							lx_dots = 2;
							return;
						end
						push_token(K_ELLIPS, 3, 8'd0, 1'b0);
						lx_state = SC_NORMAL;
						return;
					end
					close_token();
				end else begin
					k = double_op(lx_pend, c);
					if (k != K_EOF) begin
						advance_pos(c);
						push_token(k, 2, 8'd0, 1'b0);
						lx_state = SC_NORMAL;
						return;
					end
					close_token();
				end
			end
			default: lx_state = SC_NORMAL;
		endcase
		begin_token(c);
	endtask

	task automatic predict_tokens(logic [7:0] c, logic last);
		if (!lx_ended) begin
			if (c == CH_NUL) begin
				close_token();
				lx_ended = 1'b1;
			end else begin
				lex_byte(c);
			end
		end
		if (last) begin
			close_token();
			lx_tok_line = lx_line;
			lx_tok_col = lx_col;
			push_token(K_EOF, 0, 8'd0, 1'b1);
			lexer_reset();
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic send_byte(logic [7:0] c, logic last = 1'b0);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
		end
		text.valid <= 1'b1;
		text.text_byte <= c;
		text.final_byte <= last;
		@(posedge clk);
		while (!text.ready)
			@(posedge clk);
		predict_tokens(c, last);
	endtask

	task automatic send_text(string s, logic close = 1'b1);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], close && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		text.valid <= 1'b0;
		while (token_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver side
	always @(posedge clk) begin
		token_t want;
		if (arst_n && tokens.valid && tokens.ready) begin
			if (token_queue.size() == 0) begin
				report_mismatch("unexpected token kind", 64'(tokens.token_kind), 64'(0));
			end else begin
				want = token_queue.pop_front();
				if (tokens.token_kind !== want.kind)
					report_mismatch("kind", 64'(tokens.token_kind), 64'(want.kind));
				if (tokens.start_line !== want.line)
					report_mismatch("line", 64'(tokens.start_line), 64'(want.line));
				if (tokens.start_column !== want.column)
					report_mismatch("column", 64'(tokens.start_column), 64'(want.column));
				if (tokens.token_length !== want.length)
					report_mismatch("length", 64'(tokens.token_length), 64'(want.length));
				if (tokens.odd_byte !== want.odd)
					report_mismatch("odd_byte", 64'(tokens.odd_byte), 64'(want.odd));
				if (tokens.stream_done !== want.done)
					report_mismatch("stream_done", 64'(tokens.stream_done), 64'(want.done));
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			tokens.ready <= 1'b0;
		end else begin
			tokens.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((text.valid && text.ready) || (tokens.valid && tokens.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("source_token_scanner_unit regression: fail");
			$finish;
		end
	end

	task automatic test_operators();
		send_text("+->-*/%==!=!<=<<<>=>>>&&&|||^~(){}[];,..... .:");
		send_text("-=.a/x..b...", 1'b0);
		send_byte(8'h2E, 1'b1);
	endtask

	task automatic test_words();
		for (int i = 0; i < KW_COUNT; i += 9)
			send_text({kw_names[i], " "}, 1'b0);
		send_text("interfaces as1 12.3a\n", 1'b0);
		send_byte("q", 1'b1);
	endtask

	task automatic test_strings_comments();
		send_text("\"a\\\"b\" // c\n/* x ** y */ /*", 1'b0);
		send_byte("*", 1'b1);
		send_text("\"open\\", 1'b1);
		send_text("ab", 1'b0);
		send_byte(8'h00);
		send_byte("x");
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h01, 1'b1);
		send_byte(8'h00, 1'b1);
	endtask

	function automatic string random_lexeme();
		int k;
		string s;
		k = $urandom_range(9);
		case (k)
			0, 1: s = kw_names[$urandom_range(KW_COUNT - 1)];
			2: begin
				s = "";
				repeat ($urandom_range(1, 12))
					s = {s, string'(8'($urandom_range(97, 122)))};
			end
			3: s = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99));
			4: begin
				if ($urandom_range(1) != 0)
					s = "\"t\\n\"";
				else
					s = "\"q\"";
			end
			5: begin
				if ($urandom_range(1) != 0)
					s = "// c\n";
				else
					s = "/* c */";
			end
			6: begin
				if ($urandom_range(1) != 0)
					s = "->";
				else
					s = "...";
			end
			7: s = string'(8'($urandom_range(1, 255)));
			default: begin
				if ($urandom_range(1) != 0)
					s = "\n";
				else
					s = "==";
			end
		endcase
		if ($urandom_range(2) != 0)
			s = {s, " "};
		return s;
	endfunction

	task automatic test_random_stream(int n_bytes);
		string s;
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			s = random_lexeme();
			send_text(s, 1'b0);
			sent += s.len();
			if ($urandom_range(14) == 0)
				send_byte(8'($urandom_range(255)), 1'b1);
		end
		send_byte(" ", 1'b1);
	endtask

	task automatic test_backpressure();
		hold_cycles = 60;
		send_text("+++++++++;;", 1'b0);
		wait_drained();
		send_text("x=y", 1'b1);
	endtask

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		text.valid = 1'b0;
		text.text_byte = 8'd0;
		text.final_byte = 1'b0;
		tokens.ready = 1'b0;
		lexer_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_operators();
		test_words();
		test_strings_comments();
		test_random_stream(8);
		send_idle_pct = 59;
		test_random_stream(8);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		test_random_stream(8);
		send_idle_pct = 17;
		recv_stall_pct = 17;
		test_random_stream(8);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0 && token_queue.size() == 0) begin
			$display("source_token_scanner_unit regression: pass");
		end else begin
			$display("source_token_scanner_unit regression: fail");
		end
		$finish;
	end

endmodule
